### src/grid_cell_interpolation_weights_core_macros.svh
// Assertion macros for the grid cell weighting block.
`ifndef GRID_CELL_INTERPOLATION_WEIGHTS_CORE_MACROS_SVH
`define GRID_CELL_INTERPOLATION_WEIGHTS_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GCIW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define GCIW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/gciw_pkg.sv
// Shared constants, types and helpers for the grid cell weighting block.
`timescale 1ns / 1ps
package gciw_pkg;
  localparam int NDIM = 2;
  localparam int AXIS_DEPTH = 64;
  localparam int FRAC_BITS = 16;
  localparam int NCORNERS = 1 << NDIM;
  localparam int TABLE_AXES = 4;
  localparam int TABLE_ROWS = 64;
  localparam int ROW_W = 6;
  localparam int AX_W = 2;
  localparam int LEN_W = 7;
  localparam int CNT_W = $clog2(NCORNERS) + 1;
  localparam int DIV_CNT_W = 6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PARTICLE = 1'b1;

  localparam logic [2:0] REG_ESCAPE = 3'd4;

  // Effective axis length, clamped to 2..AXIS_DEPTH.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n < LEN_W'(2)) r = LEN_W'(2);
    if (n > LEN_W'(AXIS_DEPTH)) r = LEN_W'(AXIS_DEPTH);
    return r;
  endfunction

  // Per-lane result handed to the merge stage.
  typedef struct packed {
    logic [ROW_W-1:0] lo;
    logic [FRAC_BITS:0] frac;
  } lane_res_t;
endpackage

### src/gciw_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module gciw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/gciw_lane.sv
// One axis lane: binary search over the axis table and restoring division.
`timescale 1ns / 1ps
module gciw_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [gciw_pkg::ROW_W-1:0]     waddr,
  input  logic [31:0]                    wdata,
  input  logic [gciw_pkg::LEN_W-1:0]     len,
  input  logic                           go,
  input  logic signed [31:0]             prop,
  output logic                           done,
  output gciw_pkg::lane_res_t            res
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD0 = 7'b0000010, S_CHK0 = 7'b0000100,
    S_CHKH = 7'b0001000, S_SRCH = 7'b0010000, S_RDLO = 7'b0100000,
    S_DIV = 7'b1000000
  } lst_t;
  localparam int QW = gciw_pkg::FRAC_BITS + 1;
  localparam int NW = 33 + gciw_pkg::FRAC_BITS;
  typedef logic [gciw_pkg::ROW_W-1:0] ROW_W_T;

  lst_t state;
  logic [gciw_pkg::ROW_W-1:0] lo, hi, raddr;
  logic [gciw_pkg::LEN_W-1:0] n;
  logic signed [31:0] rdata;
  logic signed [31:0] p;
  logic signed [32:0] t_hi;
  logic [NW-1:0] num;
  logic [32:0] den;
  logic [32:0] rem;
  logic [QW-2:0] quo;
  logic [gciw_pkg::DIV_CNT_W-1:0] cnt;
  logic [33:0] rem_sh;
  logic [gciw_pkg::ROW_W-1:0] mid;
  logic pend;

  function automatic logic prop_le(input logic signed [31:0] a, input logic signed [31:0] b);
    return a <= b;
  endfunction

  gciw_ram #(.WIDTH(32), .DEPTH(gciw_pkg::TABLE_ROWS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign n = gciw_pkg::eff_len(len);
  assign mid = lo + ((hi - lo) >> 1);
  assign rem_sh = {rem, num[NW-1]};

  always_comb begin
    unique case (state)
      S_IDLE: raddr = '0;
      S_RD0:  raddr = '0;
      S_CHK0: raddr = ROW_W_T'(n - 1);
      S_SRCH: raddr = mid;
      S_CHKH: raddr = mid;
      S_RDLO: raddr = lo;
      S_DIV:  raddr = lo;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (go) begin
          p <= prop;
          lo <= '0;
          hi <= ROW_W_T'(n - 1);
          state <= S_RD0;
        end
        S_RD0: state <= S_CHK0;      // read of t[0] in flight
        S_CHK0: begin
          if (prop_le(p, rdata)) begin
            res.lo <= '0; res.frac <= '0; done <= 1'b1; state <= S_IDLE;
          end else state <= S_CHKH;
        end
        S_CHKH: begin
          // rdata holds t[n-1]; raddr now mid
          if (p > rdata) begin
            res.lo <= hi; res.frac <= '0; done <= 1'b1; state <= S_IDLE;
          end else begin
            t_hi <= 33'(rdata);
            pend <= 1'b0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          // each search step: issue the read of mid, then compare
          if (hi - lo <= ROW_W_T'(1)) begin
            state <= S_RDLO; pend <= 1'b0;
          end else if (!pend) pend <= 1'b1;
          else begin
            pend <= 1'b0;
            if (rdata < p) lo <= mid;
            else begin hi <= mid; t_hi <= 33'(rdata); end
          end
        end
        S_RDLO: begin
          if (!pend) pend <= 1'b1;
          else begin
            num <= NW'({33'(p) - 33'(rdata)}) << gciw_pkg::FRAC_BITS;
            den <= t_hi - 33'(rdata);
            rem <= '0; quo <= '0; cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          num <= num << 1;
          if (rem_sh >= {1'b0, den}) begin
            rem <= 33'(rem_sh - {1'b0, den}); quo <= {quo[QW-3:0], 1'b1};
          end else begin
            rem <= rem_sh[32:0]; quo <= {quo[QW-3:0], 1'b0};
          end
          if (cnt == gciw_pkg::DIV_CNT_W'(NW - 1)) begin
            state <= S_IDLE; done <= 1'b1; res.lo <= lo;
            res.frac <= (rem_sh >= {1'b0, den}) ? {quo, 1'b1} : {quo, 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### src/gciw_merge.sv
// Corner sequencer: builds index and weight for each corner from lane results.
`timescale 1ns / 1ps
module gciw_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [31:0]                mass,
  input  logic [15:0]                escape,
  input  logic [gciw_pkg::LEN_W-1:0] len [gciw_pkg::NDIM],
  input  gciw_pkg::lane_res_t        lres [gciw_pkg::NDIM],
  output logic                       strobe,
  output logic [23:0]                cell_index,
  output logic [31:0]                weight,
  output logic                       last,
  output logic                       idle
);
  localparam int KW = gciw_pkg::CNT_W;
  localparam int AW = $clog2(gciw_pkg::NDIM + 1);
  typedef enum logic [3:0] {
    M_IDLE = 4'b0001, M_ESC = 4'b0010, M_AX = 4'b0100, M_OUT = 4'b1000
  } mst_t;
  mst_t state;
  logic [KW-1:0] k;
  logic [AW-1:0] ax;
  logic [47:0] w;
  logic [23:0] idx;
  logic dead;
  logic [31:0] mass_r;
  logic high;
  logic [gciw_pkg::LEN_W-1:0] n;
  logic [gciw_pkg::ROW_W:0] c;
  logic [gciw_pkg::FRAC_BITS:0] f;
  logic [gciw_pkg::ROW_W-1:0] alo;
  logic [gciw_pkg::FRAC_BITS:0] afr;
  logic [48+gciw_pkg::FRAC_BITS:0] prod;

  always_comb begin
    alo = '0; afr = '0; n = gciw_pkg::LEN_W'(2);
    for (int i = 0; i < gciw_pkg::NDIM; i++) begin
      if (AW'(i) == ax) begin
        alo = lres[i].lo; afr = lres[i].frac; n = gciw_pkg::eff_len(len[i]);
      end
    end
    high = k[gciw_pkg::NDIM-1-int'(ax)];
    c = {1'b0, alo} + (gciw_pkg::ROW_W+1)'(high);
    f = high ? afr : ((gciw_pkg::FRAC_BITS+1)'(1) << gciw_pkg::FRAC_BITS) - afr;
    prod = w * f;
  end

  assign idle = (state == M_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE; strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        M_IDLE: if (go) begin
          mass_r <= mass; k <= '0; state <= M_ESC;
        end
        M_ESC: begin
          w <= 48'((49'(mass_r) * (49'(17'h10000) - 49'(escape))) >> 16);
          idx <= '0; dead <= 1'b0; ax <= '0; state <= M_AX;
        end
        M_AX: begin
          if ((c[gciw_pkg::ROW_W-1:0] > n - 1'b1) || c[gciw_pkg::ROW_W]) begin
            idx <= 24'(idx * n) + 24'(n - 1'b1); dead <= 1'b1;
          end else idx <= 24'(idx * n) + 24'(c);
          w <= 48'(prod >> gciw_pkg::FRAC_BITS);
          if (ax == AW'(gciw_pkg::NDIM - 1)) state <= M_OUT;
          ax <= ax + 1'b1;
        end
        M_OUT: begin
          strobe <= 1'b1;
          cell_index <= idx;
          weight <= dead ? 32'd0 : ((|w[47:32]) ? 32'hFFFFFFFF : w[31:0]);
          last <= (k == KW'(gciw_pkg::NCORNERS - 1));
          if (k == KW'(gciw_pkg::NCORNERS - 1)) state <= M_IDLE;
          else begin k <= k + 1'b1; state <= M_ESC; end
        end
        default: state <= M_IDLE;
      endcase
    end
  end
endmodule

### src/grid_cell_interpolation_weights_core.sv
// Top level of the grid cell weighting block: lanes per axis plus corner merge.
`timescale 1ns / 1ps
// Load item: taken on accept, no result, busy stays low.
// Particle item: the lanes search and divide in parallel (bit-serial divider); a lane
// skips both when the property lies outside its axis. After the slowest lane is done,
// the merge emits the corners in turn, each through M_ESC, one M_AX per axis and
// M_OUT; busy drops with the last corner.
// Results cannot be stalled. Sync reset restores registers; axis tables undefined.
module grid_cell_interpolation_weights_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [1:0]  axis,
  input  logic [5:0]  entry,
  input  logic signed [31:0] axis_value,
  input  logic signed [31:0] prop_0,
  input  logic signed [31:0] prop_1,
  input  logic signed [31:0] prop_2,
  input  logic signed [31:0] prop_3,
  input  logic [31:0] mass,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [23:0] cell_index,
  output logic [31:0] weight,
  output logic        last
);
  logic [gciw_pkg::LEN_W-1:0] axis_len [gciw_pkg::TABLE_AXES];
  logic [gciw_pkg::LEN_W-1:0] lane_len [gciw_pkg::NDIM];
  logic [15:0] escape_fraction;
  logic signed [31:0] props [gciw_pkg::TABLE_AXES];
  logic [gciw_pkg::NDIM-1:0] lane_done, got;
  gciw_pkg::lane_res_t lres [gciw_pkg::NDIM];
  logic running, merge_go, merge_idle;
  logic [31:0] mass_r;
  logic accept;

  assign props[0] = prop_0; assign props[1] = prop_1;
  assign props[2] = prop_2; assign props[3] = prop_3;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  // merge_go covers the cycle between the lanes finishing and the merge leaving idle
  assign busy = running || merge_go || !merge_idle;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gciw_pkg::TABLE_AXES; i++) axis_len[i] <= gciw_pkg::LEN_W'(2);
      escape_fraction <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < gciw_pkg::REG_ESCAPE) axis_len[cfg_index[1:0]] <= cfg_data[6:0];
      else if (cfg_index == gciw_pkg::REG_ESCAPE) escape_fraction <= cfg_data;
    end
  end

  // One lane per used axis, each with its own table memory.
  for (genvar g = 0; g < gciw_pkg::NDIM; g++) begin : g_lane
    assign lane_len[g] = axis_len[g];
    gciw_lane u_lane (
      .clk(clk), .rst(rst),
      .we(accept && (op == gciw_pkg::OP_LOAD) && (axis == 2'(g))),
      .waddr(entry), .wdata(axis_value), .len(lane_len[g]),
      .go(accept && (op == gciw_pkg::OP_PARTICLE)), .prop(props[g]),
      .done(lane_done[g]), .res(lres[g])
    );
  end

  // Wait until every lane has reported, then start the corner sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0; got <= '0; merge_go <= 1'b0;
    end else begin
      merge_go <= 1'b0;
      if (accept && op == gciw_pkg::OP_PARTICLE) begin
        running <= 1'b1; got <= '0; mass_r <= mass;
      end else if (running) begin
        if (&(got | lane_done)) begin
          running <= 1'b0; merge_go <= 1'b1;
        end
        got <= got | lane_done;
      end
    end
  end

  gciw_merge u_merge (
    .clk(clk), .rst(rst), .go(merge_go), .mass(mass_r), .escape(escape_fraction),
    .len(lane_len), .lres(lres), .strobe(strobe),
    .cell_index(cell_index), .weight(weight), .last(last), .idle(merge_idle)
  );
endmodule

### src/gciw_checker.sv
// Port-level checker for the grid cell weighting block, bound to the top.
`timescale 1ns / 1ps
`include "grid_cell_interpolation_weights_core_macros.svh"
module gciw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic strobe,
  input logic last,
  input logic [31:0] weight
);
  `GCIW_ASSERT_NEXT(a_particle_busy, clk, rst, start && !busy && op, busy, "particle not taken")
  `GCIW_ASSERT_IMPL(a_strobe_busy, clk, rst, strobe && !last, busy, "result while idle")
  `GCIW_ASSERT_NEXT(a_last_single, clk, rst, strobe && last, !strobe, "result after last")
  `GCIW_ASSERT_IMPL(a_weight_known, clk, rst, strobe, !$isunknown(weight), "weight unknown")
endmodule

bind grid_cell_interpolation_weights_core gciw_checker u_gciw_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
  .strobe(strobe), .last(last), .weight(weight)
);
